// ===== hw/rtl/window_convolution_filter_defines.svh =====
// Assertion macros used by the window convolution filter top level.
`ifndef WINDOW_CONVOLUTION_FILTER_DEFINES_SVH
`define WINDOW_CONVOLUTION_FILTER_DEFINES_SVH
`ifndef SYNTH
`define WCF_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("window filter check failed");
`define WCF_NEVER(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	!(cond)) else $error("window filter forbidden condition");
`else
`define WCF_ASSERT(lbl, prop)
`define WCF_NEVER(lbl, cond)
`endif
`endif

// ===== hw/rtl/wcf_pkg.sv =====
// Types, constants and kernel table of the window convolution filter.
`default_nettype none
package wcf_pkg;
	localparam int MAX_WIDTH = 2048;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = 12;
	localparam int DIM_W = 12;
	localparam int EMIT_W = 22;
	localparam int WIN = 5;
	localparam int HALF = WIN / 2;
	localparam int LINES = WIN - 1;
	localparam int SLOT_W = $clog2(LINES);
	localparam int TAPS = WIN * WIN;
	localparam int TAP_W = $clog2(TAPS);
	localparam int CHAN = 3;
	localparam int PIX_W = 8 * CHAN;
	localparam int MODE_W = 4;
	localparam int TERM_W = 13;
	localparam int SUM_W = 16;
	localparam int POS_W = 14;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KERNEL_MODE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_IDENTITY = 4'd0;
	localparam logic [MODE_W-1:0] MODE_BOX3 = 4'd5;
	localparam logic [MODE_W-1:0] MODE_GAUSS = 4'd6;
	localparam logic [MODE_W-1:0] MODE_BOX5 = 4'd8;
	localparam logic [MODE_W-1:0] MODE_COUNT = 4'd9;

	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_9 = 29128;
	localparam int RECIP_25 = 10486;

	localparam logic signed [4:0] KERN [9][TAPS] = '{
		'{0,0,0,0,0, 0,0,0,0,0, 0,0,1,0,0, 0,0,0,0,0, 0,0,0,0,0},
		'{0,0,0,0,0, 0,1,0,-1,0, 0,0,0,0,0, 0,-1,0,1,0, 0,0,0,0,0},
		'{0,0,0,0,0, 0,0,1,0,0, 0,1,-4,1,0, 0,0,1,0,0, 0,0,0,0,0},
		'{0,0,0,0,0, 0,-1,-1,-1,0, 0,-1,8,-1,0, 0,-1,-1,-1,0, 0,0,0,0,0},
		'{0,0,0,0,0, 0,0,-1,0,0, 0,-1,5,-1,0, 0,0,-1,0,0, 0,0,0,0,0},
		'{0,0,0,0,0, 0,1,1,1,0, 0,1,1,1,0, 0,1,1,1,0, 0,0,0,0,0},
		'{0,0,0,0,0, 0,1,2,1,0, 0,2,4,2,0, 0,1,2,1,0, 0,0,0,0,0},
		'{0,0,0,0,0, 0,0,0,1,0, 0,0,0,0,0, 0,-1,0,0,0, 0,0,0,0,0},
		'{1,1,1,1,1, 1,1,1,1,1, 1,1,1,1,1, 1,1,1,1,1, 1,1,1,1,1}
	};

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] col;
		logic [SLOT_W-1:0] slot;
		logic emit;
		logic last;
		logic [WIN-1:0] row_ok;
		logic [WIN-1:0] col_ok;
		logic [MODE_W-1:0] mode;
	} item_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} front_status_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	function automatic logic signed [4:0] kern_coef(input logic [MODE_W-1:0] mode,
		input logic [TAP_W-1:0] idx);
		if (mode < MODE_COUNT)
			return KERN[mode][idx];
		return 5'sd0;
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/wcf_front.sv =====
// Front end: raster position counters and classification of each pixel.
`default_nettype none
module wcf_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [wcf_pkg::DIM_W-1:0] image_width,
	input wire logic [wcf_pkg::DIM_W-1:0] image_height,
	input wire logic [wcf_pkg::MODE_W-1:0] kernel_mode,
	input wire logic push,
	input wire logic pad,
	input wire logic [wcf_pkg::PIX_W-1:0] pix_in,
	output wcf_pkg::item_t item,
	output wcf_pkg::front_status_t status
);
	import wcf_pkg::*;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [EMIT_W-1:0] emitted_q;
	logic [EMIT_W-1:0] whm1_q;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [2*DIM_W-1:0] wh_prod;
	logic signed [POS_W-1:0] ys, xs, yy, xx;
	logic wrap_col;

	always_comb begin
		w_eff = image_width;
		if (image_width < DIM_W'(3))
			w_eff = DIM_W'(3);
		else if (image_width > DIM_W'(MAX_WIDTH))
			w_eff = DIM_W'(MAX_WIDTH);
		h_eff = image_height;
		if (image_height < DIM_W'(3))
			h_eff = DIM_W'(3);
		else if (image_height > DIM_W'(2048))
			h_eff = DIM_W'(2048);
	end

	assign wh_prod = w_eff * h_eff;

	// Center of the window in image coordinates
	always_comb begin
		if (col_q >= COL_W'(HALF)) begin
			ys = POS_W'(row_q) - POS_W'(HALF);
			xs = POS_W'(col_q) - POS_W'(HALF);
		end else begin
			ys = POS_W'(row_q) - POS_W'(HALF + 1);
			xs = POS_W'(w_eff) - POS_W'(HALF) + POS_W'(col_q);
		end
	end

	always_comb begin
		item.pix = '0;
		if (!pad && row_q < h_eff && DIM_W'(col_q) < w_eff)
			item.pix = pix_in;
		item.col = col_q;
		item.slot = row_q[SLOT_W-1:0];
		item.emit = (row_q > ROW_W'(HALF)) ||
			(row_q == ROW_W'(HALF) && col_q >= COL_W'(HALF));
		item.last = item.emit && (emitted_q >= whm1_q);
		item.mode = (kernel_mode < MODE_COUNT) ? kernel_mode : MODE_IDENTITY;
		yy = '0;
		xx = '0;
		for (int i = 0; i < WIN; i++) begin
			yy = ys + POS_W'(i) - POS_W'(HALF);
			xx = xs + POS_W'(i) - POS_W'(HALF);
			item.row_ok[i] = (yy >= 0) && (yy < $signed(POS_W'(h_eff)));
			item.col_ok[i] = (xx >= 0) && (xx < $signed(POS_W'(w_eff)));
		end
	end

	assign wrap_col = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			emitted_q <= '0;
			whm1_q <= '0;
		end else begin
			whm1_q <= EMIT_W'(wh_prod - (2*DIM_W)'(1));
			if (push) begin
				if (item.last) begin
					col_q <= '0;
					row_q <= '0;
					emitted_q <= '0;
				end else begin
					if (item.emit)
						emitted_q <= emitted_q + EMIT_W'(1);
					if (wrap_col) begin
						col_q <= '0;
						row_q <= row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
			end
		end
	end

	assign status.col = col_q;
	assign status.row = row_q;
endmodule
`default_nettype wire

// ===== hw/rtl/wcf_fifo.sv =====
// Short item queue between the front end and the filter back end.
`default_nettype none
module wcf_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire wcf_pkg::item_t push_item,
	input wire logic pop,
	output wcf_pkg::item_t pop_item,
	output logic not_empty,
	output logic full,
	output logic [wcf_pkg::QCNT_W-1:0] count
);
	import wcf_pkg::*;

	item_t store_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	assign pop_item = store_q[rd_q];
	assign not_empty = cnt_q != '0;
	assign full = cnt_q == QCNT_W'(QDEPTH);
	assign count = cnt_q;
endmodule
`default_nettype wire

// ===== hw/rtl/wcf_back.sv =====
// Back end: line store, sliding window, kernel sums, divide and saturate.
`default_nettype none
module wcf_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_not_empty,
	input wire wcf_pkg::item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic [wcf_pkg::PIX_W-1:0] out_pix,
	output logic out_last,
	output wcf_pkg::back_status_t status
);
	import wcf_pkg::*;

	logic en;
	logic clr_q;
	logic [COL_W-1:0] clr_idx_q;

	logic [PIX_W-1:0] rd_s1 [LINES];
	logic v_s1;
	item_t item_s1;

	logic [PIX_W-1:0] win_q [WIN][WIN];
	logic v_s2, last_s2;
	logic [WIN-1:0] row_ok_s2, col_ok_s2;
	logic [MODE_W-1:0] mode_s2;

	logic signed [TERM_W-1:0] term_c [TAPS][CHAN];
	logic signed [TERM_W-1:0] term_s3 [TAPS][CHAN];
	logic v_s3, last_s3;
	logic [MODE_W-1:0] mode_s3;

	logic signed [SUM_W-1:0] rsum_c [WIN][CHAN];
	logic signed [SUM_W-1:0] rsum_s4 [WIN][CHAN];
	logic v_s4, last_s4;
	logic [MODE_W-1:0] mode_s4;

	logic signed [SUM_W-1:0] tot_c [CHAN];
	logic signed [SUM_W-1:0] tot_s5 [CHAN];
	logic v_s5, last_s5;
	logic [MODE_W-1:0] mode_s5;

	logic [7:0] chan_c [CHAN];
	logic out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_pix_q;

	assign en = !out_valid_q || out_ready;
	assign q_pop = q_not_empty && en && !clr_q;

	// Zero the line store after reset, one column of all lines per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + COL_W'(1);
			if (clr_idx_q == COL_W'(MAX_WIDTH - 1))
				clr_q <= 1'b0;
		end
	end

	for (genvar g = 0; g < LINES; g++) begin : g_line
		logic [PIX_W-1:0] mem [MAX_WIDTH];
		always_ff @(posedge clk) begin
			if (clr_q)
				mem[clr_idx_q] <= '0;
			else if (q_pop && q_item.slot == SLOT_W'(g))
				mem[q_item.col] <= q_item.pix;
			if (q_pop)
				rd_s1[g] <= mem[q_item.col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < WIN; i++)
				for (int j = 0; j < WIN; j++)
					win_q[i][j] <= '0;
		end else if (en) begin
			v_s1 <= q_pop;
			v_s2 <= v_s1 && item_s1.emit;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid_q <= v_s5;
			// Shift the window left and load the new column
			if (v_s1) begin
				for (int i = 0; i < WIN; i++) begin
					for (int j = 0; j < WIN - 1; j++)
						win_q[i][j] <= win_q[i][j+1];
					if (i < LINES)
						win_q[i][WIN-1] <= rd_s1[item_s1.slot + SLOT_W'(i)];
					else
						win_q[i][WIN-1] <= item_s1.pix;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			item_s1 <= q_item;
		if (en) begin
			last_s2 <= item_s1.last;
			row_ok_s2 <= item_s1.row_ok;
			col_ok_s2 <= item_s1.col_ok;
			mode_s2 <= item_s1.mode;
			term_s3 <= term_c;
			last_s3 <= last_s2;
			mode_s3 <= mode_s2;
			rsum_s4 <= rsum_c;
			last_s4 <= last_s3;
			mode_s4 <= mode_s3;
			tot_s5 <= tot_c;
			last_s5 <= last_s4;
			mode_s5 <= mode_s4;
			if (v_s5) begin
				out_last_q <= last_s5;
				out_pix_q <= {chan_c[2], chan_c[1], chan_c[0]};
			end
		end
	end

	// Per-tap weighted terms, taps outside the image drop out
	always_comb begin
		logic signed [TERM_W-1:0] k_ext, v_ext;
		k_ext = '0;
		v_ext = '0;
		for (int i = 0; i < WIN; i++) begin
			for (int j = 0; j < WIN; j++) begin
				k_ext = TERM_W'(kern_coef(mode_s2, TAP_W'(i * WIN + j)));
				for (int ch = 0; ch < CHAN; ch++) begin
					v_ext = $signed({{(TERM_W-8){1'b0}}, win_q[i][j][8*ch +: 8]});
					if (row_ok_s2[i] && col_ok_s2[j])
						term_c[i*WIN+j][ch] = k_ext * v_ext;
					else
						term_c[i*WIN+j][ch] = '0;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			for (int ch = 0; ch < CHAN; ch++) begin
				rsum_c[i][ch] = '0;
				for (int j = 0; j < WIN; j++)
					rsum_c[i][ch] = rsum_c[i][ch] + SUM_W'(term_s3[i*WIN+j][ch]);
			end
		end
		for (int ch = 0; ch < CHAN; ch++) begin
			tot_c[ch] = '0;
			for (int i = 0; i < WIN; i++)
				tot_c[ch] = tot_c[ch] + rsum_s4[i][ch];
		end
	end

	// Divide by reciprocal multiply (box modes) or shift (Gauss), else pass; a negative sum clamps to zero
	always_comb begin
		logic [SUM_W-1:0] u;
		logic [2*SUM_W-1:0] prod;
		logic [SUM_W-1:0] qv;
		u = '0;
		prod = '0;
		qv = '0;
		for (int ch = 0; ch < CHAN; ch++) begin
			u = tot_s5[ch];
			case (mode_s5)
				MODE_BOX3: begin
					prod = u * (2*SUM_W)'(RECIP_9);
					qv = SUM_W'(prod >> RECIP_SHIFT);
				end
				MODE_GAUSS: begin
					prod = '0;
					qv = u >> 4;
				end
				MODE_BOX5: begin
					prod = u * (2*SUM_W)'(RECIP_25);
					qv = SUM_W'(prod >> RECIP_SHIFT);
				end
				default: begin
					prod = '0;
					qv = u;
				end
			endcase
			if (tot_s5[ch] < 0)
				chan_c[ch] = 8'd0;
			else if (qv > SUM_W'(255))
				chan_c[ch] = 8'd255;
			else
				chan_c[ch] = qv[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix = out_pix_q;
	assign out_last = out_last_q;
	assign status.clearing = clr_q;
endmodule
`default_nettype wire

// ===== hw/rtl/window_convolution_filter.sv =====
// Top level of the window convolution filter: config registers, front, queue, back.
// Throughput: one pixel per clock while the sink is ready; results trail the input by two rows
// and two columns, and a result passes the queue, the s1 to s5 registers and the output register.
// The line store lanes are each read on every pop and written only for their own row slot.
// Reset: arst_n clears counters and window; the line store is then zeroed one column at a time,
// during which s_tready stays low (config writes still land).
`default_nettype none
`include "window_convolution_filter_defines.svh"
module window_convolution_filter (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [23:0] s_tdata, // red_in[7:0], green_in[15:8], blue_in[23:16]
	input wire logic [0:0] s_tuser,  // pad[0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [23:0] m_tdata,     // red_out[7:0], green_out[15:8], blue_out[23:16]
	output logic m_tlast             // last_in_frame
);
	import wcf_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [MODE_W-1:0] mode_q;
	logic cfg_wr, push;
	item_t front_item, q_item;
	front_status_t front_st;
	back_status_t back_st;
	logic q_not_empty, q_full, q_pop;
	logic [QCNT_W-1:0] q_count;

	// Register file: writes complete in the APB access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= DIM_W'(640);
			height_q <= DIM_W'(480);
			mode_q <= MODE_IDENTITY;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_IMAGE_WIDTH: width_q <= pwdata[DIM_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_KERNEL_MODE: mode_q <= pwdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_IMAGE_WIDTH: prdata = {20'd0, width_q};
			REG_IMAGE_HEIGHT: prdata = {20'd0, height_q};
			REG_KERNEL_MODE: prdata = {28'd0, mode_q};
			default: prdata = '0;
		endcase
	end

	// Accept whenever the queue has room and the line store is ready
	assign s_tready = !q_full && !back_st.clearing;
	assign push = s_tvalid && s_tready;

	wcf_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.image_width(width_q),
		.image_height(height_q),
		.kernel_mode(mode_q),
		.push(push),
		.pad(s_tuser[0]),
		.pix_in(s_tdata),
		.item(front_item),
		.status(front_st)
	);

	// Decouple classification from filtering so either side can stall
	wcf_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(front_item),
		.pop(q_pop),
		.pop_item(q_item),
		.not_empty(q_not_empty),
		.full(q_full),
		.count(q_count)
	);

	wcf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_not_empty(q_not_empty),
		.q_item(q_item),
		.q_pop(q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_pix(m_tdata),
		.out_last(m_tlast),
		.status(back_st)
	);

	// Checks
	`WCF_NEVER(a_no_accept_in_clear, back_st.clearing && s_tvalid && s_tready)
	`WCF_ASSERT(a_frame_rewind, (push && front_item.last) |=> (front_st.col == '0 && front_st.row == '0))
	`WCF_ASSERT(a_queue_bound, q_count <= QCNT_W'(QDEPTH))
	`WCF_NEVER(a_pop_empty, q_pop && !q_not_empty)
endmodule
`default_nettype wire
